@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RBV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RBV_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/rbv_pkg.sv @@
// ----------------------------------------------------------------------------
// rbv_pkg
// Widths, constants and helper functions of the rotation-between-vectors core.
// ----------------------------------------------------------------------------
`default_nettype none

package rbv_pkg;

    localparam int FRAC   = 16;            // fraction bits of every fixed-point value
    localparam int IN_W   = 18;            // input and output field width
    localparam int PROD_W = 2 * IN_W;      // product of two input fields
    localparam int K_W    = 21;            // rounded cross product component
    localparam int C_W    = 22;            // rounded dot product
    localparam int U_W    = IN_W + 1;      // fallback vector component
    localparam int SQ_W   = 40;            // sum of squares fed to the root unit
    localparam int RT_W   = SQ_W / 2;      // root width
    localparam int Q_W    = FRAC + 1;      // axis magnitude, at most one
    localparam int N_W    = IN_W;          // signed axis component
    localparam int OMC_W  = C_W + 1;       // one minus cosine
    localparam int T_W    = N_W + OMC_W - FRAC;
    localparam int W_W    = N_W + RT_W + 1 - FRAC;
    localparam int MP_W   = T_W + N_W - FRAC;
    localparam int MS_W   = MP_W + 2;
    localparam int THR_W  = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_ROW = 1'b0;
    localparam logic [0:0] REG_THR = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic signed [IN_W-1:0] t_fix;

    function automatic t_fix sat_out(input logic signed [MS_W-1:0] v);
        logic signed [MS_W-1:0] hi;
        logic signed [MS_W-1:0] lo;
        hi = {{(MS_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[IN_W-1:0];
        end else if (v < lo) begin
            return lo[IN_W-1:0];
        end
        return v[IN_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rbv_in_if.sv @@
// ----------------------------------------------------------------------------
// rbv_in_if
// Request channel carrying the source and target vectors.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbv_in_if;
    logic          valid;
    logic          ready;
    rbv_pkg::t_fix src_x;
    rbv_pkg::t_fix src_y;
    rbv_pkg::t_fix src_z;
    rbv_pkg::t_fix dst_x;
    rbv_pkg::t_fix dst_y;
    rbv_pkg::t_fix dst_z;

    modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
    modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

`default_nettype wire

@@ rtl/rbv_out_if.sv @@
// ----------------------------------------------------------------------------
// rbv_out_if
// Result channel carrying the rotation matrix and the fallback flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbv_out_if;
    logic          valid;
    logic          ready;
    rbv_pkg::t_fix m00;
    rbv_pkg::t_fix m01;
    rbv_pkg::t_fix m02;
    rbv_pkg::t_fix m10;
    rbv_pkg::t_fix m11;
    rbv_pkg::t_fix m12;
    rbv_pkg::t_fix m20;
    rbv_pkg::t_fix m21;
    rbv_pkg::t_fix m22;
    logic          used_fallback;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    used_fallback, input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    used_fallback, output ready);
endinterface

`default_nettype wire

@@ rtl/rbv_sqrt.sv @@
// ----------------------------------------------------------------------------
// rbv_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_sqrt #(
    parameter int DATA_W = 40,
    parameter int SIDE_W = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_vld,
    input  wire logic [DATA_W-1:0]     i_data,
    input  wire logic [SIDE_W-1:0]     i_side,
    output logic                       o_vld,
    output logic [DATA_W/2-1:0]        o_root,
    output logic [SIDE_W-1:0]          o_side
);

    localparam int RT_W  = DATA_W / 2;
    localparam int REM_W = RT_W + 2;

    logic [RT_W-1:0]   r_vld;
    logic [REM_W-1:0]  r_rem  [RT_W];
    logic [RT_W-1:0]   r_root [RT_W];
    logic [DATA_W-1:0] r_data [RT_W];
    logic [SIDE_W-1:0] r_side [RT_W];

    logic [REM_W-1:0]  n_rem  [RT_W];
    logic [RT_W-1:0]   n_root [RT_W];
    logic [DATA_W-1:0] n_data [RT_W];
    logic [REM_W-1:0]  rem_in [RT_W];
    logic [RT_W-1:0]   root_in[RT_W];
    logic [DATA_W-1:0] dat_in [RT_W];
    logic [REM_W-1:0]  rem_sh [RT_W];
    logic [REM_W-1:0]  trial  [RT_W];

    always_comb begin
        for (int i = 0; i < RT_W; i++) begin
            if (i == 0) begin
                rem_in[i]  = '0;
                root_in[i] = '0;
                dat_in[i]  = i_data;
            end else begin
                rem_in[i]  = r_rem[i-1];
                root_in[i] = r_root[i-1];
                dat_in[i]  = r_data[i-1];
            end
            // Bring down the next pair of radicand bits and try appending a one.
            rem_sh[i] = {rem_in[i][RT_W-1:0], dat_in[i][DATA_W-1:DATA_W-2]};
            trial[i]  = {root_in[i], 2'b01};
            if (rem_sh[i] >= trial[i]) begin
                n_rem[i]  = rem_sh[i] - trial[i];
                n_root[i] = {root_in[i][RT_W-2:0], 1'b1};
            end else begin
                n_rem[i]  = rem_sh[i];
                n_root[i] = {root_in[i][RT_W-2:0], 1'b0};
            end
            n_data[i] = dat_in[i] << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RT_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < RT_W; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
                r_data[i] <= n_data[i];
                r_side[i] <= (i == 0) ? i_side : r_side[i-1];
            end
        end
    end

    assign o_vld  = r_vld[RT_W-1];
    assign o_root = r_root[RT_W-1];
    assign o_side = r_side[RT_W-1];

endmodule

`default_nettype wire

@@ rtl/rbv_div.sv @@
// ----------------------------------------------------------------------------
// rbv_div
// Pipelined restoring divider for the axis lanes, one quotient bit per stage.
// Computes round(mag * 2^FRAC / den) for each lane against a shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rbv_div #(
    parameter int NUM_W  = 21,
    parameter int DEN_W  = 20,
    parameter int FRAC_W = 16,
    parameter int LANES  = 3,
    parameter int SIDE_W = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_vld,
    input  wire logic [NUM_W-1:0]     i_mag [LANES],
    input  wire logic [DEN_W-1:0]     i_den,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_vld,
    output logic [FRAC_W:0]           o_quo [LANES],
    output logic [SIDE_W-1:0]         o_side
);

    localparam int Q_W   = FRAC_W + 1;
    localparam int REM_W = NUM_W + FRAC_W + 1;

    logic [Q_W-1:0]    r_vld;
    logic [REM_W-1:0]  r_rem  [Q_W][LANES];
    logic [Q_W-1:0]    r_quo  [Q_W][LANES];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    logic [REM_W-1:0]  n_rem  [Q_W][LANES];
    logic [Q_W-1:0]    n_quo  [Q_W][LANES];
    logic [REM_W-1:0]  rem_in [Q_W][LANES];
    logic [Q_W-1:0]    quo_in [Q_W][LANES];
    logic [DEN_W-1:0]  den_in [Q_W];
    logic [REM_W-1:0]  dsh    [Q_W];

    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            den_in[j] = (j == 0) ? i_den : r_den[j-1];
            dsh[j]    = REM_W'(den_in[j]) << (Q_W - 1 - j);
            for (int l = 0; l < LANES; l++) begin
                if (j == 0) begin
                    // Half the divisor is added up front so that the quotient rounds.
                    rem_in[j][l] = {1'b0, i_mag[l], {FRAC_W{1'b0}}}
                                 + REM_W'(i_den >> 1);
                    quo_in[j][l] = '0;
                end else begin
                    rem_in[j][l] = r_rem[j-1][l];
                    quo_in[j][l] = r_quo[j-1][l];
                end
                if (rem_in[j][l] >= dsh[j]) begin
                    n_rem[j][l] = rem_in[j][l] - dsh[j];
                    n_quo[j][l] = quo_in[j][l] | (Q_W'(1) << (Q_W - 1 - j));
                end else begin
                    n_rem[j][l] = rem_in[j][l];
                    n_quo[j][l] = quo_in[j][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < Q_W; j++) begin
                r_den[j]  <= den_in[j];
                r_side[j] <= (j == 0) ? i_side : r_side[j-1];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[j][l] <= n_rem[j][l];
                    r_quo[j][l] <= n_quo[j][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_quo[Q_W-1][l];
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/rotation_between_vectors_core.sv @@
// Depth: a request passes through 45 register stages in all on its way to the
// output register.
// Throughput: one request per cycle while not stalled; the 20-stage square root
// and the 17-stage divider are fully pipelined, so nothing iterates in place.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) clears all valid bits; row_convention resets
// to 0 and parallel_threshold to 1.
`default_nettype none
`include "assert_macros.svh"

module rotation_between_vectors_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rbv_in_if.sink                             i_in,
    rbv_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rbv_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [rbv_pkg::DATA_W-1:0]    pwdata,
    output logic      [rbv_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int FRAC   = rbv_pkg::FRAC;
    localparam int IN_W   = rbv_pkg::IN_W;
    localparam int PROD_W = rbv_pkg::PROD_W;
    localparam int K_W    = rbv_pkg::K_W;
    localparam int C_W    = rbv_pkg::C_W;
    localparam int U_W    = rbv_pkg::U_W;
    localparam int SQ_W   = rbv_pkg::SQ_W;
    localparam int RT_W   = rbv_pkg::RT_W;
    localparam int Q_W    = rbv_pkg::Q_W;
    localparam int N_W    = rbv_pkg::N_W;
    localparam int OMC_W  = rbv_pkg::OMC_W;
    localparam int T_W    = rbv_pkg::T_W;
    localparam int W_W    = rbv_pkg::W_W;
    localparam int MP_W   = rbv_pkg::MP_W;
    localparam int MS_W   = rbv_pkg::MS_W;
    localparam int THR_W  = rbv_pkg::THR_W;
    localparam int KS_W   = 3 * K_W + C_W;
    localparam int US_W   = 3 * U_W;
    localparam int DS_W   = C_W + RT_W + 2 + 3;
    localparam int TP_W   = N_W + OMC_W;
    localparam int WP_W   = N_W + RT_W + 1;
    localparam int MPP_W  = T_W + N_W;

    // ---------------- configuration ----------------
    logic             r_row;
    logic [THR_W-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
            r_thr <= rbv_pkg::THR_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                rbv_pkg::REG_ROW: r_row <= pwdata[0];
                rbv_pkg::REG_THR: r_thr <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rbv_pkg::REG_ROW: prdata = {{(rbv_pkg::DATA_W-1){1'b0}}, r_row};
            rbv_pkg::REG_THR: prdata = {{(rbv_pkg::DATA_W-THR_W){1'b0}}, r_thr};
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipeline enable ----------------
    logic r_out_vld;
    logic en;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // ---------------- stage 1: products ----------------
    logic signed [IN_W-1:0]   a [3];
    logic signed [IN_W-1:0]   b [3];
    logic                     r1_vld;
    logic signed [PROD_W-1:0] r1_p [9];
    logic signed [IN_W-1:0]   r1_a [3];

    assign a[0] = i_in.src_x;
    assign a[1] = i_in.src_y;
    assign a[2] = i_in.src_z;
    assign b[0] = i_in.dst_x;
    assign b[1] = i_in.dst_y;
    assign b[2] = i_in.dst_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p[0] <= PROD_W'(a[1]) * PROD_W'(b[2]);
            r1_p[1] <= PROD_W'(a[2]) * PROD_W'(b[1]);
            r1_p[2] <= PROD_W'(a[2]) * PROD_W'(b[0]);
            r1_p[3] <= PROD_W'(a[0]) * PROD_W'(b[2]);
            r1_p[4] <= PROD_W'(a[0]) * PROD_W'(b[1]);
            r1_p[5] <= PROD_W'(a[1]) * PROD_W'(b[0]);
            r1_p[6] <= PROD_W'(a[0]) * PROD_W'(b[0]);
            r1_p[7] <= PROD_W'(a[1]) * PROD_W'(b[1]);
            r1_p[8] <= PROD_W'(a[2]) * PROD_W'(b[2]);
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= a[i];
            end
        end
    end

    // ---------------- stage 2: cross, dot, fallback vector ----------------
    logic signed [PROD_W:0]   kd [3];
    logic signed [PROD_W+1:0] cd;
    logic signed [U_W-1:0]    ab [3];
    logic signed [U_W-1:0]    n_u [3];
    logic                     r2_vld;
    logic signed [K_W-1:0]    r2_k [3];
    logic signed [C_W-1:0]    r2_c;
    logic signed [U_W-1:0]    r2_u [3];

    always_comb begin
        kd[0] = (PROD_W+1)'(r1_p[0]) - (PROD_W+1)'(r1_p[1]) + (PROD_W+1)'(1 << (FRAC - 1));
        kd[1] = (PROD_W+1)'(r1_p[2]) - (PROD_W+1)'(r1_p[3]) + (PROD_W+1)'(1 << (FRAC - 1));
        kd[2] = (PROD_W+1)'(r1_p[4]) - (PROD_W+1)'(r1_p[5]) + (PROD_W+1)'(1 << (FRAC - 1));
        cd    = (PROD_W+2)'(r1_p[6]) + (PROD_W+2)'(r1_p[7]) + (PROD_W+2)'(r1_p[8])
              + (PROD_W+2)'(1 << (FRAC - 1));
        for (int i = 0; i < 3; i++) begin
            ab[i] = (r1_a[i] < 0) ? -U_W'(r1_a[i]) : U_W'(r1_a[i]);
        end
        // Cross with the coordinate axis along the smallest component of the source.
        if (ab[0] < ab[1] && ab[0] < ab[2]) begin
            n_u[0] = '0;
            n_u[1] = U_W'(r1_a[2]);
            n_u[2] = -U_W'(r1_a[1]);
        end else if (ab[0] >= ab[1] && ab[1] < ab[2]) begin
            n_u[0] = -U_W'(r1_a[2]);
            n_u[1] = '0;
            n_u[2] = U_W'(r1_a[0]);
        end else begin
            n_u[0] = U_W'(r1_a[1]);
            n_u[1] = -U_W'(r1_a[0]);
            n_u[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_k[i] <= kd[i][PROD_W:FRAC];
                r2_u[i] <= n_u[i];
            end
            r2_c <= cd[PROD_W+1:FRAC];
        end
    end

    // ---------------- stage 3: squares ----------------
    logic                     r3_vld;
    logic [SQ_W-1:0]          r3_kk [3];
    logic [SQ_W-1:0]          r3_uu [3];
    logic signed [K_W-1:0]    r3_k [3];
    logic signed [C_W-1:0]    r3_c;
    logic signed [U_W-1:0]    r3_u [3];
    logic signed [2*K_W-1:0]  ksq [3];
    logic signed [2*U_W-1:0]  usq [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ksq[i] = (2*K_W)'(r2_k[i]) * (2*K_W)'(r2_k[i]);
            usq[i] = (2*U_W)'(r2_u[i]) * (2*U_W)'(r2_u[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_kk[i] <= ksq[i][SQ_W-1:0];
                r3_uu[i] <= SQ_W'(usq[i]);
                r3_k[i]  <= r2_k[i];
                r3_u[i]  <= r2_u[i];
            end
            r3_c <= r2_c;
        end
    end

    // ---------------- square roots: sine and fallback length ----------------
    logic [SQ_W-1:0] ksum;
    logic [SQ_W-1:0] usum;
    logic            sqk_vld;
    logic            squ_vld;
    logic [RT_W-1:0] sqk_root;
    logic [RT_W-1:0] squ_root;
    logic [KS_W-1:0] sqk_side;
    logic [US_W-1:0] squ_side;

    assign ksum = r3_kk[0] + r3_kk[1] + r3_kk[2];
    assign usum = r3_uu[0] + r3_uu[1] + r3_uu[2];

    rbv_sqrt #(
        .DATA_W (SQ_W),
        .SIDE_W (KS_W)
    ) u_sqrt_k (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_data  (ksum),
        .i_side  ({r3_k[0], r3_k[1], r3_k[2], r3_c}),
        .o_vld   (sqk_vld),
        .o_root  (sqk_root),
        .o_side  (sqk_side)
    );

    rbv_sqrt #(
        .DATA_W (SQ_W),
        .SIDE_W (US_W)
    ) u_sqrt_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r3_vld),
        .i_data  (usum),
        .i_side  ({r3_u[0], r3_u[1], r3_u[2]}),
        .o_vld   (squ_vld),
        .o_root  (squ_root),
        .o_side  (squ_side)
    );

    // ---------------- axis selection ----------------
    logic signed [K_W-1:0] sk [3];
    logic signed [C_W-1:0] sc;
    logic signed [U_W-1:0] su [3];
    logic                  sel_fb;
    logic signed [K_W-1:0] sel_num [3];
    logic                  r4_vld;
    logic [K_W-1:0]        r4_mag [3];
    logic [2:0]            r4_neg;
    logic [RT_W-1:0]       r4_den;
    logic signed [C_W-1:0] r4_c;
    logic [RT_W-1:0]       r4_s;
    logic                  r4_fb;
    logic                  r4_zero;

    assign {sk[0], sk[1], sk[2], sc} = sqk_side;
    assign {su[0], su[1], su[2]}     = squ_side;
    // A zero sine takes the fallback whatever the threshold.
    assign sel_fb = (sqk_root == '0) || (sqk_root < RT_W'(r_thr));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sel_num[i] = sel_fb ? K_W'(su[i]) : sk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r4_mag[i] <= (sel_num[i] < 0) ? K_W'(-sel_num[i]) : K_W'(sel_num[i]);
                r4_neg[i] <= sel_num[i] < 0;
            end
            r4_den  <= sel_fb ? squ_root : sqk_root;
            r4_c    <= sc;
            r4_s    <= sqk_root;
            r4_fb   <= sel_fb;
            r4_zero <= sel_fb && (squ_root == '0);
        end
    end

    // ---------------- axis division ----------------
    logic            dv_vld;
    logic [Q_W-1:0]  dv_quo [3];
    logic [DS_W-1:0] dv_side;
    logic signed [C_W-1:0] dc;
    logic [RT_W-1:0] ds;
    logic            dfb;
    logic            dzero;
    logic [2:0]      dneg;

    rbv_div #(
        .NUM_W  (K_W),
        .DEN_W  (RT_W),
        .FRAC_W (FRAC),
        .LANES  (3),
        .SIDE_W (DS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r4_vld),
        .i_mag   (r4_mag),
        .i_den   (r4_den),
        .i_side  ({r4_c, r4_s, r4_fb, r4_zero, r4_neg}),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign {dc, ds, dfb, dzero, dneg} = dv_side;

    // ---------------- signed axis and one minus cosine ----------------
    logic                    r5_vld;
    logic signed [N_W-1:0]   r5_n [3];
    logic signed [OMC_W-1:0] r5_omc;
    logic signed [C_W-1:0]   r5_c;
    logic [RT_W-1:0]         r5_s;
    logic                    r5_fb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dzero) begin
                    r5_n[i] <= '0;
                end else if (dneg[i]) begin
                    r5_n[i] <= -N_W'(dv_quo[i]);
                end else begin
                    r5_n[i] <= N_W'(dv_quo[i]);
                end
            end
            r5_omc <= OMC_W'(1 << FRAC) - OMC_W'(dc);
            r5_c   <= dc;
            r5_s   <= ds;
            r5_fb  <= dfb;
        end
    end

    // ---------------- t = n(1-c), w = n s ----------------
    logic signed [TP_W-1:0] tp [3];
    logic signed [WP_W-1:0] wp [3];
    logic                   r6_vld;
    logic signed [T_W-1:0]  r6_t [3];
    logic signed [W_W-1:0]  r6_w [3];
    logic signed [N_W-1:0]  r6_n [3];
    logic signed [C_W-1:0]  r6_c;
    logic                   r6_fb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tp[i] = TP_W'(r5_n[i]) * TP_W'(r5_omc) + TP_W'(1 << (FRAC - 1));
            wp[i] = WP_W'(r5_n[i]) * $signed({1'b0, r5_s}) + WP_W'(1 << (FRAC - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_t[i] <= tp[i][TP_W-1:FRAC];
                r6_w[i] <= wp[i][WP_W-1:FRAC];
                r6_n[i] <= r5_n[i];
            end
            r6_c  <= r5_c;
            r6_fb <= r5_fb;
        end
    end

    // ---------------- outer product ----------------
    logic signed [MPP_W-1:0] mpp [3][3];
    logic                    r7_vld;
    logic signed [MP_W-1:0]  r7_mp [3][3];
    logic signed [W_W-1:0]   r7_w [3];
    logic signed [C_W-1:0]   r7_c;
    logic                    r7_fb;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mpp[r][c] = MPP_W'(r6_t[c]) * MPP_W'(r6_n[r]) + MPP_W'(1 << (FRAC - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r7_mp[r][c] <= mpp[r][c][MPP_W-1:FRAC];
                end
                r7_w[r] <= r6_w[r];
            end
            r7_c  <= r6_c;
            r7_fb <= r6_fb;
        end
    end

    // ---------------- diagonal, skew, saturation, output register ----------------
    logic signed [MS_W-1:0] ms [3][3];
    rbv_pkg::t_fix          mo [3][3];
    rbv_pkg::t_fix          r_m [3][3];
    logic                   r_fb;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ms[r][c] = MS_W'(r7_mp[r][c]) + ((r == c) ? MS_W'(r7_c) : MS_W'(0));
            end
        end
        ms[0][1] = ms[0][1] - MS_W'(r7_w[2]);
        ms[0][2] = ms[0][2] + MS_W'(r7_w[1]);
        ms[1][0] = ms[1][0] + MS_W'(r7_w[2]);
        ms[1][2] = ms[1][2] - MS_W'(r7_w[0]);
        ms[2][0] = ms[2][0] - MS_W'(r7_w[1]);
        ms[2][1] = ms[2][1] + MS_W'(r7_w[0]);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mo[r][c] = rbv_pkg::sat_out(r_row ? ms[c][r] : ms[r][c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m  <= mo;
            r_fb <= r7_fb;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r7_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= i_in.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= sqk_vld;
            r5_vld    <= dv_vld;
            r6_vld    <= r5_vld;
            r7_vld    <= r6_vld;
            r_out_vld <= r7_vld;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.m00           = r_m[0][0];
    assign o_out.m01           = r_m[0][1];
    assign o_out.m02           = r_m[0][2];
    assign o_out.m10           = r_m[1][0];
    assign o_out.m11           = r_m[1][1];
    assign o_out.m12           = r_m[1][2];
    assign o_out.m20           = r_m[2][0];
    assign o_out.m21           = r_m[2][1];
    assign o_out.m22           = r_m[2][2];
    assign o_out.used_fallback = r_fb;

    // ---------------- assertions ----------------
    `RBV_ASSERT(a_req_enters, (i_in.valid && i_in.ready) |=> r1_vld, "accepted request did not enter the first stage")
    `RBV_ASSERT(a_sqrt_aligned, sqk_vld == squ_vld, "square root lanes out of step")
    `RBV_ASSERT(a_stall_freezes, (!en && r7_vld) |=> r7_vld, "pipeline advanced during a stall")
    `RBV_ASSERT_RST(a_rst_clears, !i_rst_n |=> !r_out_vld, "output valid after reset")

endmodule

`default_nettype wire
